// ----- rtl/sdtq_pkg.sv -----
// ----------------------------------------------------------------------------
// sdtq_pkg
// Shared types and constants for the sorted deadline timer queue: the command
// that the front end hands to the back end, mode codes and result kinds.
// ----------------------------------------------------------------------------
package sdtq_pkg;

  // Default number of timer slots.
  localparam int NUM_TIMERS_DEF = 16;

  // Largest forward distance; also the answer for an idle slot or empty queue.
  localparam logic [31:0] MAX_DIFF = 32'h7fffffff;

  // Most expiries that one tick may report.
  localparam int RESULT_LIMIT = 16;

  // Input mode codes.
  localparam logic [2:0] MODE_START   = 3'd0;
  localparam logic [2:0] MODE_STOP    = 3'd1;
  localparam logic [2:0] MODE_TICK    = 3'd2;
  localparam logic [2:0] MODE_REMAIN  = 3'd3;
  localparam logic [2:0] MODE_PENDING = 3'd4;

  // Result kinds.
  localparam logic [1:0] EV_EXPIRED = 2'd0;
  localparam logic [1:0] EV_REMAIN  = 2'd1;
  localparam logic [1:0] EV_PENDING = 2'd2;

  // Decoded operation.
  typedef enum logic [2:0] {
    OP_START,
    OP_STOP,
    OP_TICK,
    OP_REMAIN,
    OP_PENDING
  } cmd_op_t;

  // One classified command.
  typedef struct packed {
    cmd_op_t     op;
    logic        in_range;
    logic [3:0]  idx;
    logic [30:0] delay;
    logic [31:0] tag;
  } cmd_t;

endpackage

// ----- rtl/sdtq_front.sv -----
// ----------------------------------------------------------------------------
// sdtq_front
// Accepts input transactions, decodes the mode, drops those that have no
// effect and buffers the rest in a two-entry command queue for the back end.
// ----------------------------------------------------------------------------
module sdtq_front #(
  parameter int NUM_TIMERS = sdtq_pkg::NUM_TIMERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_mode,
  input  logic [3:0]         in_timer_index,
  input  logic [30:0]        in_delay_ticks,
  input  logic [31:0]        in_user_tag,
  output logic               cmd_valid,
  output sdtq_pkg::cmd_t     cmd,
  input  logic               cmd_pop
);
  import sdtq_pkg::*;

  cmd_t       fifo_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       accept;
  logic       keep;
  logic       in_range;
  cmd_t       dec;

  assign in_stall = (count_r == 2'd2);
  assign accept   = in_valid && !in_stall;
  assign in_range = (32'(in_timer_index) < 32'(NUM_TIMERS));

  // Decode the mode; start and stop of a slot out of range, and unknown modes, are dropped.
  always_comb begin
    dec.in_range = in_range;
    dec.idx      = in_timer_index;
    dec.delay    = in_delay_ticks;
    dec.tag      = in_user_tag;
    dec.op       = OP_TICK;
    keep         = 1'b0;
    case (in_mode)
      MODE_START: begin
        dec.op = OP_START;
        keep   = in_range;
      end
      MODE_STOP: begin
        dec.op = OP_STOP;
        keep   = in_range;
      end
      MODE_TICK: begin
        dec.op = OP_TICK;
        keep   = 1'b1;
      end
      MODE_REMAIN: begin
        dec.op = OP_REMAIN;
        keep   = 1'b1;
      end
      MODE_PENDING: begin
        dec.op = OP_PENDING;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = fifo_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (accept && keep) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (cmd_pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if ((accept && keep) && !cmd_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!(accept && keep) && cmd_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Command storage.
  always_ff @(posedge clk) begin
    if (accept && keep) begin
      fifo_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// ----- rtl/sdtq_back.sv -----
// ----------------------------------------------------------------------------
// sdtq_back
// Executes commands: keeps the tick count, the timer table and the sorted
// order queue, walks the queue to insert, expires due timers on a tick and
// answers queries through an output register.
// ----------------------------------------------------------------------------
module sdtq_back #(
  parameter int NUM_TIMERS = sdtq_pkg::NUM_TIMERS_DEF,
  localparam int SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1,
  localparam int CNT_W  = $clog2(NUM_TIMERS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  sdtq_pkg::cmd_t     cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_event_kind,
  output logic [3:0]         out_expired_index,
  output logic [31:0]        out_tag_out,
  output logic [30:0]        out_ticks_left,
  output logic               out_last_of_run,
  output logic [CNT_W-1:0]   queue_len
);
  import sdtq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REMOVE,
    S_WALK,
    S_INSERT,
    S_STOP,
    S_TICK,
    S_QUERY
  } state_t;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [31:0]       tick_r, tick_nxt;
  logic [31:0]       dl_r [NUM_TIMERS];
  logic [31:0]       tag_r [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] act_r, act_nxt;
  logic [SLOT_W-1:0] q_r [NUM_TIMERS];
  logic [SLOT_W-1:0] q_nxt [NUM_TIMERS];
  logic [CNT_W-1:0]  qlen_r, qlen_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic              held_v_r, held_v_nxt;
  logic [SLOT_W-1:0] held_slot_r, held_slot_nxt;
  logic [31:0]       held_tag_r, held_tag_nxt;

  logic              out_valid_r;
  logic [1:0]        out_kind_r;
  logic [3:0]        out_idx_r;
  logic [31:0]       out_tag_r;
  logic [30:0]       out_left_r;
  logic              out_last_r;

  logic              out_free;
  logic              out_load;
  logic [1:0]        out_kind_nxt;
  logic [3:0]        out_idx_nxt;
  logic [31:0]       out_tag_nxt;
  logic [30:0]       out_left_nxt;
  logic              out_last_nxt;

  logic              tbl_wr;
  logic [SLOT_W-1:0] cmd_slot;
  logic [SLOT_W-1:0] rd_slot;
  logic [31:0]       rd_dist;
  logic [CNT_W-1:0]  rm_pos;
  logic              due;

  assign cmd_slot  = SLOT_W'(cmd_r.idx);
  assign out_free  = !out_valid_r || !out_stall;
  assign cmd_pop   = (state_r == S_IDLE) && cmd_valid;
  assign queue_len = qlen_r;

  // One table read per cycle: the slot being compared or reported.
  always_comb begin
    case (state_r)
      S_WALK:  rd_slot = q_r[pos_r[SLOT_W-1:0]];
      S_QUERY: rd_slot = (cmd_r.op == OP_REMAIN) ? cmd_slot : q_r[0];
      default: rd_slot = q_r[0];
    endcase
  end
  assign rd_dist = dl_r[rd_slot] - tick_r;

  // Position of the command's slot in the queue, for removal.
  always_comb begin
    rm_pos = CNT_W'(0);
    for (int j = NUM_TIMERS - 1; j >= 0; j--) begin
      if ((q_r[j] == cmd_slot) && (CNT_W'(j) < qlen_r)) begin
        rm_pos = CNT_W'(j);
      end
    end
  end

  // Head of the queue is due on the current tick and the report limit is not reached.
  assign due = (qlen_r != CNT_W'(0)) && (cnt_r < 5'(RESULT_LIMIT)) &&
               ((rd_dist == 32'd0) || (rd_dist >= MAX_DIFF));

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    tick_nxt      = tick_r;
    act_nxt       = act_r;
    q_nxt         = q_r;
    qlen_nxt      = qlen_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    held_v_nxt    = held_v_r;
    held_slot_nxt = held_slot_r;
    held_tag_nxt  = held_tag_r;
    tbl_wr        = 1'b0;
    out_load      = 1'b0;
    out_kind_nxt  = EV_EXPIRED;
    out_idx_nxt   = 4'(held_slot_r);
    out_tag_nxt   = held_tag_r;
    out_left_nxt  = 31'd0;
    out_last_nxt  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt = cmd;
          case (cmd.op)
            OP_START:   state_nxt = S_REMOVE;
            OP_STOP:    state_nxt = S_STOP;
            OP_TICK: begin
              tick_nxt  = tick_r + 32'd1;
              cnt_nxt   = 5'd0;
              state_nxt = S_TICK;
            end
            default:    state_nxt = S_QUERY;
          endcase
        end
      end
      S_REMOVE: begin
        // Take a running slot out of the queue, then write the new timer.
        if (act_r[cmd_slot]) begin
          for (int j = 0; j < NUM_TIMERS - 1; j++) begin
            if (CNT_W'(j) >= rm_pos) begin
              q_nxt[j] = q_r[j + 1];
            end
          end
          qlen_nxt = qlen_r - CNT_W'(1);
        end
        tbl_wr            = 1'b1;
        act_nxt[cmd_slot] = 1'b1;
        pos_nxt           = CNT_W'(0);
        state_nxt         = S_WALK;
      end
      S_WALK: begin
        // Skip entries already past and those due sooner than the new one.
        if (pos_r == qlen_r) begin
          state_nxt = S_INSERT;
        end else if ((rd_dist > MAX_DIFF) || ({1'b0, cmd_r.delay} > rd_dist)) begin
          pos_nxt = pos_r + CNT_W'(1);
        end else begin
          state_nxt = S_INSERT;
        end
      end
      S_INSERT: begin
        for (int j = 1; j < NUM_TIMERS; j++) begin
          if (CNT_W'(j) > pos_r) begin
            q_nxt[j] = q_r[j - 1];
          end
        end
        q_nxt[pos_r[SLOT_W-1:0]] = cmd_slot;
        qlen_nxt  = qlen_r + CNT_W'(1);
        state_nxt = S_IDLE;
      end
      S_STOP: begin
        if (act_r[cmd_slot]) begin
          for (int j = 0; j < NUM_TIMERS - 1; j++) begin
            if (CNT_W'(j) >= rm_pos) begin
              q_nxt[j] = q_r[j + 1];
            end
          end
          qlen_nxt          = qlen_r - CNT_W'(1);
          act_nxt[cmd_slot] = 1'b0;
        end
        state_nxt = S_IDLE;
      end
      S_TICK: begin
        // The previous expiry is held until it is known whether it is the last.
        if (due) begin
          if (!held_v_r || out_free) begin
            out_load      = held_v_r;
            held_v_nxt    = 1'b1;
            held_slot_nxt = rd_slot;
            held_tag_nxt  = tag_r[rd_slot];
            for (int j = 0; j < NUM_TIMERS - 1; j++) begin
              q_nxt[j] = q_r[j + 1];
            end
            qlen_nxt         = qlen_r - CNT_W'(1);
            act_nxt[rd_slot] = 1'b0;
            cnt_nxt          = cnt_r + 5'd1;
          end
        end else if (!held_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_last_nxt = 1'b1;
          held_v_nxt   = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      S_QUERY: begin
        out_tag_nxt  = 32'd0;
        out_last_nxt = 1'b1;
        if (cmd_r.op == OP_REMAIN) begin
          out_kind_nxt = EV_REMAIN;
          out_idx_nxt  = cmd_r.idx;
          if (!cmd_r.in_range || !act_r[cmd_slot]) begin
            out_left_nxt = MAX_DIFF[30:0];
          end else if (rd_dist >= MAX_DIFF) begin
            out_left_nxt = 31'd0;
          end else begin
            out_left_nxt = rd_dist[30:0];
          end
        end else begin
          out_kind_nxt = EV_PENDING;
          if (qlen_r == CNT_W'(0)) begin
            out_idx_nxt  = 4'd0;
            out_left_nxt = MAX_DIFF[30:0];
          end else begin
            out_idx_nxt  = 4'(rd_slot);
            out_left_nxt = (rd_dist > MAX_DIFF) ? 31'd0 : rd_dist[30:0];
          end
        end
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= 32'd0;
      act_r       <= '0;
      qlen_r      <= CNT_W'(0);
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      tick_r   <= tick_nxt;
      act_r    <= act_nxt;
      qlen_r   <= qlen_nxt;
      held_v_r <= held_v_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    q_r         <= q_nxt;
    pos_r       <= pos_nxt;
    cnt_r       <= cnt_nxt;
    held_slot_r <= held_slot_nxt;
    held_tag_r  <= held_tag_nxt;
    if (out_load) begin
      out_kind_r <= out_kind_nxt;
      out_idx_r  <= out_idx_nxt;
      out_tag_r  <= out_tag_nxt;
      out_left_r <= out_left_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  // Timer table write on start.
  always_ff @(posedge clk) begin
    if (tbl_wr) begin
      dl_r[cmd_slot]  <= tick_r + {1'b0, cmd_r.delay};
      tag_r[cmd_slot] <= cmd_r.tag;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_kind    = out_kind_r;
  assign out_expired_index = out_idx_r;
  assign out_tag_out       = out_tag_r;
  assign out_ticks_left    = out_left_r;
  assign out_last_of_run   = out_last_r;

endmodule

// ----- rtl/sorted_deadline_timer_queue.sv -----
// A query answer is loaded into the output register; a stop removes the slot from the queue.
// A start removes a running slot, writes the table, walks the queue to the insert point and inserts.
// A tick reports at most 16 expiries, one queue pop per cycle while the output is not stalled.
// Commands run one at a time; the two-entry queue accepts input while it has room.
// Reset (synchronous, rst_n low) clears the tick count, active marks and queue.
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue
// Timer queue sorted by wrap-aware deadline: a front end decodes and buffers
// transactions, a back end runs start, stop, tick and query commands.
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue #(
  parameter int NUM_TIMERS = sdtq_pkg::NUM_TIMERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic [3:0]  in_timer_index,
  input  logic [30:0] in_delay_ticks,
  input  logic [31:0] in_user_tag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [3:0]  out_expired_index,
  output logic [31:0] out_tag_out,
  output logic [30:0] out_ticks_left,
  output logic        out_last_of_run
);
  import sdtq_pkg::*;

  localparam int CNT_W = $clog2(NUM_TIMERS + 1);

  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_pop;
  logic [CNT_W-1:0] queue_len;

  // Decode and buffer.
  sdtq_front #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_timer_index(in_timer_index),
    .in_delay_ticks(in_delay_ticks),
    .in_user_tag   (in_user_tag),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  // Execute.
  sdtq_back #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_expired_index(out_expired_index),
    .out_tag_out      (out_tag_out),
    .out_ticks_left   (out_ticks_left),
    .out_last_of_run  (out_last_of_run),
    .queue_len        (queue_len)
  );

`ifndef ASSERT_OFF
  // The queue never holds more entries than there are slots.
  a_qlen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    queue_len <= CNT_W'(NUM_TIMERS))
    else $error("queue length exceeds slot count");

  // A query answer is always the only result of its transaction.
  a_query_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind != EV_EXPIRED) |-> out_last_of_run)
    else $error("query answer not marked last");

  // An expiry carries no remaining ticks.
  a_expiry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_EXPIRED) |-> (out_ticks_left == 31'd0))
    else $error("expiry with nonzero ticks left");

  // Query answers carry no tag.
  a_query_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind != EV_EXPIRED) |-> (out_tag_out == 32'd0))
    else $error("query answer with nonzero tag");
`endif

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the sorted deadline timer queue. A software
// model of the timer table and deadline queue predicts every expiry and query
// answer. A monitor compares each result transaction, field by field, with
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import sdtq_pkg::*;

  localparam int SLOTS = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  idx;
    logic [30:0] delay;
    logic [31:0] tag;
  } command_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  idx;
    logic [31:0] tag;
    logic [30:0] left;
    logic        last;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_mode = MODE_TICK;
  logic [3:0]  in_timer_index = '0;
  logic [30:0] in_delay_ticks = '0;
  logic [31:0] in_user_tag = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_event_kind;
  logic [3:0]  out_expired_index;
  logic [31:0] out_tag_out;
  logic [30:0] out_ticks_left;
  logic        out_last_of_run;

  sorted_deadline_timer_queue dut (.*);

  always #5 clk = ~clk;

  // Model state of the timer table and the sorted queue.
  logic [31:0] now_ticks;
  logic [31:0] due_at [SLOTS];
  logic [31:0] tag_of [SLOTS];
  logic        running [SLOTS];
  logic [3:0]  order [$];

  command_t cmd_backlog [$];
  answer_t  awaited [$];
  int       errors = 0;
  bit       long_hold_done = 1'b0;
  int       accepted = 0;

  function automatic logic [31:0] ticks_to(logic [3:0] slot);
    return due_at[slot] - now_ticks;
  endfunction

  function automatic void drop_from_order(logic [3:0] slot);
    foreach (order[i]) begin
      if (order[i] == slot) begin
        order.delete(i);
        return;
      end
    end
  endfunction

  function automatic answer_t make_answer(logic [1:0] kind, logic [3:0] idx,
                                          logic [31:0] tag, logic [31:0] left);
    answer_t a;
    a.kind = kind;
    a.idx = idx;
    a.tag = tag;
    a.left = left[30:0];
    a.last = 1'b0;
    return a;
  endfunction

  // Apply one accepted command to the model and queue the answers it causes.
  function automatic void apply_command(command_t c);
    int pos;
    int n;
    logic [31:0] d;
    logic [31:0] dnew;
    logic [3:0] head;
    answer_t a;
    n = 0;
    case (c.mode)
      MODE_START: begin
        if (running[c.idx]) begin
          drop_from_order(c.idx);
          running[c.idx] = 1'b0;
        end
        if (order.size() < SLOTS) begin
          due_at[c.idx] = now_ticks + {1'b0, c.delay};
          tag_of[c.idx] = c.tag;
          running[c.idx] = 1'b1;
          dnew = ticks_to(c.idx);
          pos = 0;
          while (pos < order.size()) begin
            d = ticks_to(order[pos]);
            if (!(d > MAX_DIFF || dnew > d)) break;
            pos++;
          end
          order.insert(pos, c.idx);
        end
      end
      MODE_STOP: begin
        if (running[c.idx]) begin
          running[c.idx] = 1'b0;
          drop_from_order(c.idx);
        end
      end
      MODE_TICK: begin
        now_ticks = now_ticks + 32'd1;
        while (order.size() > 0 && n < RESULT_LIMIT) begin
          head = order[0];
          d = ticks_to(head);
          if (d != 0 && d < MAX_DIFF) break;
          void'(order.pop_front());
          running[head] = 1'b0;
          awaited.push_back(make_answer(EV_EXPIRED, head, tag_of[head], 32'd0));
          n++;
        end
        if (n > 0) awaited[awaited.size() - 1].last = 1'b1;
      end
      MODE_REMAIN: begin
        d = MAX_DIFF;
        if (running[c.idx]) begin
          d = ticks_to(c.idx);
          if (d >= MAX_DIFF) d = 32'd0;
        end
        a = make_answer(EV_REMAIN, c.idx, 32'd0, d);
        a.last = 1'b1;
        awaited.push_back(a);
      end
      MODE_PENDING: begin
        d = MAX_DIFF;
        head = '0;
        if (order.size() > 0) begin
          head = order[0];
          d = ticks_to(head);
          if (d > MAX_DIFF) d = 32'd0;
        end
        a = make_answer(EV_PENDING, head, 32'd0, d);
        a.last = 1'b1;
        awaited.push_back(a);
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_cmd(logic [2:0] mode, logic [3:0] idx,
                                    logic [30:0] delay, logic [31:0] tag);
    command_t c;
    c.mode = mode;
    c.idx = idx;
    c.delay = delay;
    c.tag = tag;
    cmd_backlog.push_back(c);
  endfunction

  // Driver: bursts of transactions separated by random gaps.
  command_t on_bus;
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_command(on_bus);
        accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          on_bus = cmd_backlog.pop_front();
          in_mode <= on_bus.mode;
          in_timer_index <= on_bus.idx;
          in_delay_ticks <= on_bus.delay;
          in_user_tag <= on_bus.tag;
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off once enough traffic is in.
  int hold_count = 0;
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (!long_hold_done && accepted >= 200) begin
      out_stall <= 1'b1;
      hold_count++;
      if (hold_count >= LONG_HOLD) long_hold_done = 1'b1;
    end else begin
      stall_phase = (stall_phase + 1) % 64;
      if (stall_phase < 20) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 2) == 0);
    end
  end

  // Monitor: compare each result transaction with the oldest prediction.
  answer_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited.size() == 0) begin
        $error("unexpected result transaction kind=%0d idx=%0d",
               out_event_kind, out_expired_index);
        errors++;
      end else begin
        want = awaited.pop_front();
        if (out_event_kind !== want.kind) begin
          $error("event_kind expected %0d got %0d", want.kind, out_event_kind);
          errors++;
        end
        if (out_expired_index !== want.idx) begin
          $error("expired_index expected %0d got %0d", want.idx, out_expired_index);
          errors++;
        end
        if (out_tag_out !== want.tag) begin
          $error("tag_out expected %h got %h", want.tag, out_tag_out);
          errors++;
        end
        if (out_ticks_left !== want.left) begin
          $error("ticks_left expected %h got %h", want.left, out_ticks_left);
          errors++;
        end
        if (out_last_of_run !== want.last) begin
          $error("last_of_run expected %0d got %0d", want.last, out_last_of_run);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction or delivered result.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    int sel;
    logic [30:0] dly;
    now_ticks = '0;
    foreach (running[i]) begin
      running[i] = 1'b0;
      due_at[i] = '0;
      tag_of[i] = '0;
    end

    // Directed: extremes, every mode, ties, restart and idle stop.
    queue_cmd(MODE_PENDING, 4'd0, '0, '0);
    queue_cmd(MODE_START, 4'd0, 31'd0, 32'hffffffff);
    queue_cmd(MODE_REMAIN, 4'd0, '0, '0);
    queue_cmd(MODE_TICK, 4'd0, '0, '0);
    queue_cmd(MODE_START, 4'd15, 31'h7fffffff, 32'h0);
    queue_cmd(MODE_REMAIN, 4'd15, '0, '0);
    queue_cmd(MODE_START, 4'd1, 31'd3, 32'h11111111);
    queue_cmd(MODE_START, 4'd2, 31'd3, 32'h22222222);
    queue_cmd(MODE_PENDING, 4'd0, '0, '0);
    queue_cmd(MODE_START, 4'd1, 31'd5, 32'h33333333);
    queue_cmd(MODE_STOP, 4'd2, '0, '0);
    queue_cmd(MODE_STOP, 4'd3, '0, '0);
    queue_cmd(MODE_REMAIN, 4'd3, '0, '0);
    queue_cmd(3'd7, 4'd5, 31'd1, 32'h1);
    queue_cmd(3'd5, 4'd6, 31'd1, 32'h1);
    for (int t = 0; t < 6; t++) queue_cmd(MODE_TICK, 4'd0, '0, '0);
    queue_cmd(MODE_STOP, 4'd15, '0, '0);
    // Every slot due on the same tick.
    for (int s = 0; s < SLOTS; s++) queue_cmd(MODE_START, s[3:0], 31'd1, $urandom);
    queue_cmd(MODE_TICK, 4'd0, '0, '0);

    // Random: mostly short timers that expire, with queries and some noise.
    for (int k = 0; k < 431; k++) begin
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) dly = 31'($urandom >> 1);
      else dly = 31'($urandom_range(0, 12));
      if (sel < 35) queue_cmd(MODE_START, 4'($urandom), dly, $urandom);
      else if (sel < 45) queue_cmd(MODE_STOP, 4'($urandom), 31'($urandom), $urandom);
      else if (sel < 72) queue_cmd(MODE_TICK, 4'($urandom), 31'($urandom), $urandom);
      else if (sel < 86) queue_cmd(MODE_REMAIN, 4'($urandom), 31'($urandom), $urandom);
      else if (sel < 96) queue_cmd(MODE_PENDING, 4'($urandom), 31'($urandom), $urandom);
      else queue_cmd(3'($urandom_range(5, 7)), 4'($urandom), 31'($urandom), $urandom);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog.size() > 0 || in_valid || awaited.size() > 0 || !long_hold_done)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && awaited.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
